// ===== rtl/azl_pkg.sv =====
// ----------------------------------------------------------------------------
// azl_pkg - shared types and constants for the zone mean / luminance block
// Field widths, stream packing, divider sizing and controller command bus.
// ----------------------------------------------------------------------------
package azl_pkg;

  // default number of exposure zones
  localparam int unsigned ZONES_DEF  = 255;

  // stream widths
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 32;

  // field widths
  localparam int unsigned ZIDX_W     = 8;
  localparam int unsigned BIN_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MEAN_W     = 8;
  localparam int unsigned LUMA_W     = 17;

  // divider sizing: divisor up to 3 * 65535, quotient up to 65536
  localparam int unsigned DEN_W      = 18;
  localparam int unsigned QUO_W      = 17;
  localparam int unsigned DSH_W      = DEN_W + QUO_W - 1;
  localparam int unsigned LOAD_NUM_W = 24;

  // query term: mean * gain, clamped to 128.0 in Q8.8
  localparam int unsigned PROD_W     = MEAN_W + GAIN_W;
  localparam int unsigned TERM_W     = 16;
  localparam logic [TERM_W-1:0] TERM_CAP = 16'h8000;
  localparam int unsigned TERM_CAP_INT   = 32768;

  // all histogram bins together sum to this
  localparam logic [BIN_W-1:0] BIN_FULL = 16'hFFFF;

  // function and result kind codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the accepted input beat
    logic arith;      // form numerator and divisor of a load
    logic rd;         // read one zone and advance the sweep
    logic div_start;  // launch the shared divider
    logic finish;     // write back and load the result register
  } azl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func;        // function of the item in work
    logic sweep_last;  // sweep address is at the last zone
    logic pipe_empty;  // no read or product still in flight
    logic div_busy;    // divider still iterating
  } azl_sts_t;

endpackage

// ===== rtl/azl_div.sv =====
// ----------------------------------------------------------------------------
// azl_div - iterative restoring divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module azl_div import azl_pkg::*; #(
  parameter int unsigned NUM_W = LOAD_NUM_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned ITER_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              busy_r, busy_nxt;
  logic [DSH_W-1:0]  rem_ext;
  logic [DSH_W-1:0]  diff;
  logic              ge;

  // one compare and subtract per cycle against the shifted divisor
  always_comb begin
    rem_ext  = DSH_W'(rem_r);
    ge       = (rem_ext >= dsh_r);
    diff     = rem_ext - dsh_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, {(QUO_W-1){1'b0}}};
      quo_nxt  = '0;
      iter_nxt = ITER_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = diff[NUM_W-1:0];
      end
      quo_nxt  = {quo_r[QUO_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      iter_nxt = iter_r - 1'b1;
      busy_nxt = (iter_r != ITER_W'(1));
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // advance the working registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    iter_r <= iter_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/azl_dp.sv =====
// ----------------------------------------------------------------------------
// azl_dp - datapath of the zone mean / luminance block
// Input capture, load arithmetic, zone store, multiply-accumulate sweep,
// shared divider and the result register.
// ----------------------------------------------------------------------------
module azl_dp import azl_pkg::*; #(
  parameter int unsigned ZONES = ZONES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  azl_cmd_t              cmd,
  output azl_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int unsigned AW    = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned SUM_W = $clog2(ZONES * TERM_CAP_INT + 1);
  localparam int unsigned NUM_W = (SUM_W + 1 > LOAD_NUM_W) ? SUM_W + 1 : LOAD_NUM_W;
  localparam int unsigned PAD_W = OUT_DATA_W - LUMA_W - 1 - MEAN_W;

  // captured item
  logic                  func_r;
  logic [ZIDX_W-1:0]     zi_r;
  logic [BIN_W-1:0]      b0_r, b1_r, b3_r, b4_r;
  logic [GAIN_W-1:0]     gain_r;

  // load arithmetic
  logic [BIN_W-1:0]      b2;
  logic [LOAD_NUM_W-1:0] num_nxt, num_r;
  logic [DEN_W-1:0]      den_nxt, den_r;

  // zone store and sweep
  logic [MEAN_W-1:0]     mem [ZONES];
  logic [AW-1:0]         addr_r;
  logic [MEAN_W-1:0]     rdata_r;
  logic                  rd_v_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  prod_v_r;
  logic [TERM_W-1:0]     term;
  logic [SUM_W-1:0]      acc_r;

  // divider and result
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_busy;
  logic [QUO_W-1:0]      quo;
  logic                  den_zero;
  logic [MEAN_W-1:0]     mean;
  logic                  in_range;
  logic                  mem_we;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_tuser;
      zi_r   <= in_tdata[7:0];
      b0_r   <= in_tdata[23:8];
      b1_r   <= in_tdata[39:24];
      b3_r   <= in_tdata[55:40];
      b4_r   <= in_tdata[71:56];
      gain_r <= in_tdata[87:72];
    end
  end

  // middle bin, then weighted sum 16*b1 + 72*b2 + 128*b3 and divisor
  always_comb begin
    b2      = BIN_FULL - b0_r - b1_r - b3_r - b4_r;
    num_nxt = (LOAD_NUM_W'(b1_r) << 4) + (LOAD_NUM_W'(b2) << 6)
            + (LOAD_NUM_W'(b2) << 3) + (LOAD_NUM_W'(b3_r) << 7);
    den_nxt = DEN_W'(b1_r) + DEN_W'(b2) + DEN_W'(b3_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.arith) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  // sweep address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= '0;
    end else if (cmd.rd) begin
      addr_r <= addr_r + 1'b1;
    end
  end

  // zone store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(zi_r)] <= mean;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  // pipeline valid bits of the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.rd;
      prod_v_r <= rd_v_r;
    end
  end

  // mean times gain, registered
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= PROD_W'(rdata_r) * PROD_W'(gain_r);
    end
  end

  // clamp to 128.0 and accumulate
  assign term = (prod_r > PROD_W'(TERM_CAP)) ? TERM_CAP : prod_r[TERM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + SUM_W'(term);
    end
  end

  // shared divider: load mean, or twice the sum over the zone count
  always_comb begin
    if (func_r == FUNC_QUERY) begin
      div_num = NUM_W'({acc_r, 1'b0});
      div_den = DEN_W'(ZONES);
    end else begin
      div_num = NUM_W'(num_r);
      div_den = den_r;
    end
  end

  azl_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // mean and write back of a load
  assign den_zero = (den_r == '0);
  assign mean     = den_zero ? '0 : quo[MEAN_W-1:0];
  assign in_range = (32'(zi_r) < ZONES);
  assign mem_we   = cmd.finish && (func_r == FUNC_LOAD) && in_range;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_user_r <= func_r;
      if (func_r == FUNC_QUERY) begin
        out_data_r <= {{PAD_W{1'b0}}, quo, 1'b0, {MEAN_W{1'b0}}};
      end else begin
        out_data_r <= {{PAD_W{1'b0}}, {LUMA_W{1'b0}}, den_zero, mean};
      end
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  // status to the controller
  always_comb begin
    sts.func       = func_r;
    sts.sweep_last = (addr_r == AW'(ZONES - 1));
    sts.pipe_empty = !rd_v_r && !prod_v_r;
    sts.div_busy   = div_busy;
  end

endmodule

// ===== rtl/azl_ctrl.sv =====
// ----------------------------------------------------------------------------
// azl_ctrl - sequencer of the zone mean / luminance block
// Steps an item through load arithmetic or the zone sweep, the divide and
// the hand-over to the result register.
// ----------------------------------------------------------------------------
module azl_ctrl import azl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  azl_sts_t sts,
  output azl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARITH,
    S_SWEEP,
    S_DRAIN,
    S_DIVGO,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   res_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign res_free  = !out_valid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ARITH;
        end
      end
      // form the load sums, then branch on the captured function
      S_ARITH: begin
        cmd.arith = 1'b1;
        state_nxt = (sts.func == FUNC_QUERY) ? S_SWEEP : S_DIVGO;
      end
      S_SWEEP: begin
        cmd.rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and the result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/ae_zone_mean_and_luminance.sv =====
// ----------------------------------------------------------------------------
// ae_zone_mean_and_luminance - per-zone mean brightness and frame luminance
// Loads zone histograms into a mean store and answers luminance queries.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (in_*): in_tuser selects the function, 0 loads one zone's
//   bin counts, 1 queries the luminance estimate for the gain in in_tdata.
//   Result stream (out_*): one beat per input beat, in order; out_tuser
//   gives the kind, 0 for a zone mean, 1 for a luminance.
//   Sequence: a load passes the weighted sum, the divider launch, the
//   bit-serial divide of all 17 quotient bits, a state that sees it finish
//   and the load of the result register; a query passes a decode state,
//   the one-zone-per-cycle sweep over the single read port of the zone
//   store, the drain of the read and multiply stages, then the same divide
//   and hand-over.
//   One item is in work at a time; the next beat is taken in the cycle
//   after the previous result is loaded into the output register, even
//   while that result still waits for out_tready.
//   A stalled receiver holds the result; an item that finishes meanwhile
//   waits until the output register is free.
//   Reset (rst_n low, synchronous) empties the pipeline and drops any
//   pending result; the zone store is not cleared, so every zone must be
//   loaded before the first query.
// ----------------------------------------------------------------------------
module ae_zone_mean_and_luminance import azl_pkg::*; #(
  parameter int unsigned ZONES = ZONES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] zone_index, [23:8] bin0_count, [39:24] bin1_count,
  // [55:40] bin3_count, [71:56] bin4_count, [87:72] gain
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] zone_mean, [8] divide_error, [25:9] luminance, [31:26] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] kind
  output logic                  out_tuser
);

  azl_cmd_t cmd;
  azl_sts_t sts;

  azl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  azl_dp #(
    .ZONES (ZONES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/azl_checker.sv =====
// ----------------------------------------------------------------------------
// azl_checker - port-level checks of the zone mean / luminance block
// Result stream handshake and the shape of each kind of result beat.
// ----------------------------------------------------------------------------
module azl_checker import azl_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // a stalled result beat stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // a stalled result beat keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // a zone mean carries no luminance and never exceeds 128
  a_mean_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == FUNC_LOAD) |->
      (out_tdata[25:9] == '0) && (out_tdata[7:0] <= 8'd128))
    else $error("zone mean beat malformed");

  // a luminance carries no mean or error and never exceeds 1.0
  a_luma_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == FUNC_QUERY) |->
      (out_tdata[8:0] == '0) && (out_tdata[25:9] <= 17'd65536))
    else $error("luminance beat malformed");

  // a zero divisor reports a zero mean
  a_err_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tdata[7:0] == '0))
    else $error("divide error with non-zero mean");

endmodule

bind ae_zone_mean_and_luminance azl_checker u_azl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== verif/tb_ae_zone_mean_and_luminance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ae_zone_mean_and_luminance - self-checking bench for the zone mean block
// Loads zone histograms and queries the frame luminance over random
// handshake gaps. An in-bench mean store predicts every result beat, and a
// monitor compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ae_zone_mean_and_luminance;
  import azl_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct {
    logic             func;
    logic [ZIDX_W-1:0] zone;
    logic [BIN_W-1:0]  b0;
    logic [BIN_W-1:0]  b1;
    logic [BIN_W-1:0]  b3;
    logic [BIN_W-1:0]  b4;
    logic [GAIN_W-1:0] gain;
  } zone_beat_t;

  typedef struct {
    logic              kind;
    logic [MEAN_W-1:0] mean;
    logic              derr;
    logic [LUMA_W-1:0] luma;
  } zone_result_t;

  // histogram shapes for load beats
  typedef enum {MIX_FORMED, MIX_LIVE, MIX_NOISE, MIX_NODIV} load_mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  zone_beat_t   beat_backlog[$];
  zone_result_t due_results[$];
  logic [MEAN_W-1:0] zone_means [ZONES_DEF];
  int unsigned  errors = 0;
  int unsigned  in_gap = 0;
  int unsigned  out_gap = 0;
  int unsigned  quiet_cycles = 0;
  bit           calm = 1'b0;

  ae_zone_mean_and_luminance #(.ZONES(ZONES_DEF)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the result of one accepted beat and update the mean store
  function automatic zone_result_t zone_mean_or_luma(zone_beat_t b);
    zone_result_t      r;
    logic [BIN_W-1:0]  mid;
    int unsigned       wsum;
    int unsigned       cnt;
    longint unsigned   total;
    longint unsigned   term;
    r = '{kind: FUNC_LOAD, mean: '0, derr: 1'b0, luma: '0};
    if (b.func == FUNC_LOAD) begin
      mid  = BIN_FULL - b.b0 - b.b1 - b.b3 - b.b4;
      wsum = 16 * int'(b.b1) + 72 * int'(mid) + 128 * int'(b.b3);
      cnt  = int'(b.b1) + int'(mid) + int'(b.b3);
      if (cnt == 0) begin
        r.derr = 1'b1;
      end else begin
        r.mean = MEAN_W'(wsum / cnt);
      end
      // out-of-range zones leave the store alone
      if (b.zone < ZONES_DEF) begin
        zone_means[b.zone] = r.mean;
      end
    end else begin
      r.kind = FUNC_QUERY;
      total  = 0;
      for (int i = 0; i < ZONES_DEF; i++) begin
        term = longint'(zone_means[i]) * longint'(b.gain);
        if (term > TERM_CAP_INT) begin
          term = TERM_CAP_INT;
        end
        total += term;
      end
      r.luma = LUMA_W'((total * 2) / ZONES_DEF);
    end
    return r;
  endfunction

  task automatic queue_beat(input logic func, input logic [ZIDX_W-1:0] zone,
                            input logic [BIN_W-1:0] b0, input logic [BIN_W-1:0] b1,
                            input logic [BIN_W-1:0] b3, input logic [BIN_W-1:0] b4,
                            input logic [GAIN_W-1:0] gain);
    beat_backlog.push_back('{func: func, zone: zone, b0: b0, b1: b1, b3: b3,
                             b4: b4, gain: gain});
  endtask

  // Query with random content in the fields that a query ignores
  task automatic queue_query(input logic [GAIN_W-1:0] gain);
    queue_beat(FUNC_QUERY, ZIDX_W'($urandom_range(0, 255)),
               BIN_W'($urandom_range(0, 65535)), BIN_W'($urandom_range(0, 65535)),
               BIN_W'($urandom_range(0, 65535)), BIN_W'($urandom_range(0, 65535)),
               gain);
  endtask

  // Load with a histogram of the given shape
  task automatic queue_load(input logic [ZIDX_W-1:0] zone, input load_mix_t mix);
    int unsigned cut [4];
    int unsigned hold;
    int unsigned b0, b1, b3, b4;
    b0 = 0; b1 = 0; b3 = 0; b4 = 0;
    case (mix)
      MIX_NOISE: begin
        b0 = $urandom_range(0, 65535);
        b1 = $urandom_range(0, 65535);
        b3 = $urandom_range(0, 65535);
        b4 = $urandom_range(0, 65535);
      end
      MIX_NODIV: begin
        b0 = $urandom_range(0, 65535);
        b4 = 65535 - b0;
      end
      default: begin
        // split the full count at four sorted cut points
        do begin
          foreach (cut[i]) cut[i] = $urandom_range(0, 65535);
          for (int i = 1; i < 4; i++) begin
            for (int j = i; j > 0 && cut[j-1] > cut[j]; j--) begin
              hold = cut[j]; cut[j] = cut[j-1]; cut[j-1] = hold;
            end
          end
          b0 = cut[0];
          b1 = cut[1] - cut[0];
          b3 = cut[3] - cut[2];
          b4 = 65535 - cut[3];
        end while (mix == MIX_LIVE && b0 + b4 == 65535);
      end
    endcase
    queue_beat(FUNC_LOAD, zone, BIN_W'(b0), BIN_W'(b1), BIN_W'(b3), BIN_W'(b4),
               GAIN_W'($urandom_range(0, 65535)));
  endtask

  // Input driver: predict on acceptance, then present the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        zone_beat_t cur;
        cur.func = in_tuser;
        {cur.gain, cur.b4, cur.b3, cur.b1, cur.b0, cur.zone} = in_tdata;
        due_results.push_back(zone_mean_or_luma(cur));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap    <= $urandom_range(0, 15);
          in_tvalid <= 1'b0;
        end else if (beat_backlog.size() > 0) begin
          zone_beat_t nxt;
          nxt = beat_backlog.pop_front();
          in_tuser  <= nxt.func;
          in_tdata  <= {nxt.gain, nxt.b4, nxt.b3, nxt.b1, nxt.b0, nxt.zone};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          errors++;
        end else begin
          zone_result_t want;
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("zone_mean", 32'(want.mean), 32'(out_tdata[7:0]));
          check_field("divide_error", 32'(want.derr), 32'(out_tdata[8]));
          check_field("luminance", 32'(want.luma), 32'(out_tdata[25:9]));
          check_field("pad", 0, 32'(out_tdata[31:26]));
        end
      end
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap    <= $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (beat_backlog.size() != 0 || in_tvalid || due_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int unsigned fill_order [ZONES_DEF];
    int unsigned pick;
    int unsigned hold;
    int unsigned roll;
    logic [ZIDX_W-1:0] zone;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed loads: empty and saturated histograms, zero divisors,
    // single-bin histograms, out-of-range zone, gain ignored on a load
    queue_beat(FUNC_LOAD, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(FUNC_LOAD, 8'd254, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(FUNC_LOAD, 8'd255, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    queue_beat(FUNC_LOAD, 8'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(FUNC_LOAD, 8'd2, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    queue_beat(FUNC_LOAD, 8'd3, 16'd30000, 16'h0000, 16'h0000, 16'd35535, 16'h1234);
    queue_beat(FUNC_LOAD, 8'd4, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(FUNC_LOAD, 8'd5, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    queue_beat(FUNC_LOAD, 8'd6, 16'd65533, 16'd1, 16'd1, 16'h0000, 16'h0000);
    queue_beat(FUNC_LOAD, 8'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h5555);
    queue_beat(FUNC_LOAD, 8'd170, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'hAAAA);
    queue_beat(FUNC_LOAD, 8'd85, 16'hAAAA, 16'h5555, 16'h0001, 16'h0000, 16'h0000);

    // fill every zone in shuffled order with a nonzero mean
    foreach (fill_order[i]) fill_order[i] = i;
    for (int i = ZONES_DEF - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      hold = fill_order[i]; fill_order[i] = fill_order[pick]; fill_order[pick] = hold;
    end
    foreach (fill_order[i]) queue_load(ZIDX_W'(fill_order[i]), MIX_LIVE);

    // hold the sender until every result is back
    wait_drained();

    // directed queries: zero gain, smallest step, unity, clamp edges, full scale
    queue_query(16'h0000);
    queue_query(16'h0001);
    queue_query(16'h0100);
    queue_query(16'h00FF);
    queue_query(16'h8000);
    queue_query(16'hFFFF);
    wait_drained();

    // random mix of loads and queries, then a stretch with no idling
    for (int n = 0; n < 175; n++) begin
      if (n == 150) begin
        wait_drained();
        calm = 1'b1;
      end
      roll = $urandom_range(0, 99);
      zone = ($urandom_range(0, 19) == 0) ? 8'd255
                                           : ZIDX_W'($urandom_range(0, ZONES_DEF - 1));
      if (roll < 15) begin
        queue_query(GAIN_W'($urandom_range(0, 65535)));
      end else if (roll < 80) begin
        queue_load(zone, MIX_FORMED);
      end else if (roll < 95) begin
        queue_load(zone, MIX_NOISE);
      end else begin
        queue_load(zone, MIX_NODIV);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ae_zone_mean_and_luminance.f =====
rtl/azl_pkg.sv
rtl/azl_div.sv
rtl/azl_dp.sv
rtl/azl_ctrl.sv
rtl/ae_zone_mean_and_luminance.sv
rtl/azl_checker.sv
verif/tb_ae_zone_mean_and_luminance.sv
